// File: rtl/min_heap_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Min-heap priority queue assertion macros
// Shared property wrappers clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define MHPQ_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be seen out of reset.
`define MHPQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Sizes, item types, cell control and cell status structures.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY = 256;
    localparam int ARITY    = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = $clog2(ARITY + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_UPDATE = 2'd2,
        FUNC_GET    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [15:0] in_vertex;
        logic [30:0] in_cost;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        out_vertex;
        logic signed [31:0] out_cost;
        t_status            status;
        logic [8:0]         entry_total;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic [30:0] cost;
        logic [15:0] vertex;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WRITE,
        OP_SEL_COUNT,
        OP_LOAD_ROOT,
        OP_UP,
        OP_DOWN,
        OP_SCAN_START,
        OP_SCAN,
        OP_SET,
        OP_SEL_TOK
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SEL_LAST,
        ST_LOAD_ROOT,
        ST_UP,
        ST_DOWN,
        ST_SCAN_START,
        ST_SCAN,
        ST_SET,
        ST_SEL_TOK,
        ST_GET,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] count;
        t_entry           entry;
    } t_ctl;

    typedef struct packed {
        t_entry            entry;
        logic              live;
        logic              mark;
        logic              tok;
        logic              hit;
        logic              sel;
        logic              swap_up;
        logic              go_down;
        logic [SLOT_W-1:0] down_j;
    } t_cell_out;

    function automatic logic entry_less(input t_entry a, input t_entry b);
        return {a.cost, a.vertex} < {b.cost, b.vertex};
    endfunction

endpackage

// File: rtl/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Row of heap cells driven by one controller; one result per item.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  input   | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
//  output  | o_out_valid | i_out_stall | o_out_item (t_out_item)
//
// Insert writes the entry and moves it up. Remove loads the last entry at the root
// and moves it down. Update/get scan one cell per cycle; update then moves it up.
// Entries move at most log_A N levels. Full inserts and empty removes skip the heap.
// o_in_stall is high from acceptance until the result is in the output register.
// A result waits in the output register while i_out_stall is high.
// Synchronous active-low reset empties the heap; entries are not cleared.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_defines.svh"

module min_heap_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mhpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mhpq_pkg::t_out_item o_out_item
);

    mhpq_pkg::t_cell_out w_cell [mhpq_pkg::CAPACITY];
    mhpq_pkg::t_cell_out [mhpq_pkg::ARITY-1:0] w_kids [mhpq_pkg::CAPACITY];
    mhpq_pkg::t_ctl      ctl;

    mhpq_pkg::t_state    r_state, n_state;
    mhpq_pkg::t_in_item  r_req, n_req;
    mhpq_pkg::t_out_item r_res, n_res;
    mhpq_pkg::t_out_item r_out, n_out;
    logic                r_ovalid, n_ovalid;
    logic [mhpq_pkg::CNT_W-1:0] r_count, n_count;
    mhpq_pkg::t_entry    r_bus, w_bus;

    logic any_swap, any_down, any_hit, any_tok_live;
    logic [mhpq_pkg::CAPACITY-1:0] w_marks, w_swaps;

    for (genvar i = 0; i < mhpq_pkg::CAPACITY; i++) begin : g_cell
        for (genvar j = 0; j < mhpq_pkg::ARITY; j++) begin : g_kid
            if (mhpq_pkg::ARITY * i + j + 1 < mhpq_pkg::CAPACITY) begin : g_on
                assign w_kids[i][j] = w_cell[mhpq_pkg::ARITY * i + j + 1];
            end else begin : g_off
                assign w_kids[i][j] = '0;
            end
        end
        if (i == 0) begin : g_root
            mhpq_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_index  (mhpq_pkg::IDX_W'(i)),
                .i_slot   ('0),
                .i_ctl    (ctl),
                .i_parent ('0),
                .i_prev   ('0),
                .i_child  (w_kids[i]),
                .o_cell   (w_cell[i])
            );
        end else begin : g_node
            mhpq_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_index  (mhpq_pkg::IDX_W'(i)),
                .i_slot   (mhpq_pkg::SLOT_W'((i - 1) % mhpq_pkg::ARITY + 1)),
                .i_ctl    (ctl),
                .i_parent (w_cell[(i - 1) / mhpq_pkg::ARITY]),
                .i_prev   (w_cell[i - 1]),
                .i_child  (w_kids[i]),
                .o_cell   (w_cell[i])
            );
        end
    end

    always_comb begin
        any_swap     = 1'b0;
        any_down     = 1'b0;
        any_hit      = 1'b0;
        any_tok_live = 1'b0;
        w_bus        = '0;
        for (int i = 0; i < mhpq_pkg::CAPACITY; i++) begin
            any_swap     = any_swap | w_cell[i].swap_up;
            any_down     = any_down | w_cell[i].go_down;
            any_hit      = any_hit | w_cell[i].hit;
            any_tok_live = any_tok_live | (w_cell[i].tok & w_cell[i].live);
            w_bus        = w_bus | (w_cell[i].sel ? w_cell[i].entry : '0);
            w_marks[i]   = w_cell[i].mark;
            w_swaps[i]   = w_cell[i].swap_up;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_count   = r_count;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        ctl.op    = mhpq_pkg::OP_NOP;
        ctl.count = r_count;
        ctl.entry.cost   = r_req.in_cost;
        ctl.entry.vertex = r_req.in_vertex;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_item;
                    n_res = '0;
                    case (i_in_item.func)
                        mhpq_pkg::FUNC_INSERT: begin
                            if (r_count >= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
                                n_res.status = mhpq_pkg::STAT_FULL;
                                n_state      = mhpq_pkg::ST_DONE;
                            end else begin
                                n_state = mhpq_pkg::ST_WRITE;
                            end
                        end
                        mhpq_pkg::FUNC_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = mhpq_pkg::STAT_EMPTY;
                                n_state      = mhpq_pkg::ST_DONE;
                            end else begin
                                n_res.out_vertex = w_cell[0].entry.vertex;
                                n_res.out_cost   = {1'b0, w_cell[0].entry.cost};
                                n_count          = r_count - 1'b1;
                                n_state          = mhpq_pkg::ST_SEL_LAST;
                            end
                        end
                        default: begin
                            n_state = mhpq_pkg::ST_SCAN_START;
                        end
                    endcase
                end
            end
            mhpq_pkg::ST_WRITE: begin
                ctl.op  = mhpq_pkg::OP_WRITE;
                n_count = r_count + 1'b1;
                n_state = mhpq_pkg::ST_UP;
            end
            mhpq_pkg::ST_SEL_LAST: begin
                ctl.op  = mhpq_pkg::OP_SEL_COUNT;
                n_state = mhpq_pkg::ST_LOAD_ROOT;
            end
            mhpq_pkg::ST_LOAD_ROOT: begin
                ctl.op    = mhpq_pkg::OP_LOAD_ROOT;
                ctl.entry = r_bus;
                n_state   = mhpq_pkg::ST_DOWN;
            end
            mhpq_pkg::ST_UP: begin
                ctl.op = mhpq_pkg::OP_UP;
                if (!any_swap) begin
                    n_state = mhpq_pkg::ST_DONE;
                end
            end
            mhpq_pkg::ST_DOWN: begin
                ctl.op = mhpq_pkg::OP_DOWN;
                if (!any_down) begin
                    n_state = mhpq_pkg::ST_DONE;
                end
            end
            mhpq_pkg::ST_SCAN_START: begin
                ctl.op  = mhpq_pkg::OP_SCAN_START;
                n_state = mhpq_pkg::ST_SCAN;
            end
            mhpq_pkg::ST_SCAN: begin
                ctl.op = mhpq_pkg::OP_SCAN;
                if (any_hit) begin
                    n_state = (r_req.func == mhpq_pkg::FUNC_UPDATE) ?
                              mhpq_pkg::ST_SET : mhpq_pkg::ST_SEL_TOK;
                end else if (!any_tok_live) begin
                    n_res.status = mhpq_pkg::STAT_NOT_FOUND;
                    if (r_req.func == mhpq_pkg::FUNC_GET) begin
                        n_res.out_cost = '1;
                    end
                    n_state = mhpq_pkg::ST_DONE;
                end
            end
            mhpq_pkg::ST_SET: begin
                ctl.op  = mhpq_pkg::OP_SET;
                n_state = mhpq_pkg::ST_UP;
            end
            mhpq_pkg::ST_SEL_TOK: begin
                ctl.op  = mhpq_pkg::OP_SEL_TOK;
                n_state = mhpq_pkg::ST_GET;
            end
            mhpq_pkg::ST_GET: begin
                n_res.out_cost = {1'b0, r_bus.cost};
                n_state        = mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out             = r_res;
                    n_out.entry_total = r_count[8:0];
                    n_out.is_empty    = (r_count == '0);
                    n_ovalid          = 1'b1;
                    n_state           = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
        r_bus <= w_bus;
        if (!i_rst_n) begin
            r_state  <= mhpq_pkg::ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != mhpq_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    `MHPQ_CHECK(a_one_mark, $onehot0(w_marks), "more than one moving entry")
    `MHPQ_CHECK(a_one_swap, $onehot0(w_swaps), "more than one cell swapping up")
    `MHPQ_NEVER(a_count_range, r_count > mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY),
                "entry count above capacity")
    `MHPQ_CHECK(a_idle_no_mark, (r_state == mhpq_pkg::ST_IDLE) |-> (w_marks == '0),
                "moving entry left while idle")

endmodule

// File: rtl/mhpq_cell.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue cell
// Holds one heap slot; swaps with its parent or a child, passes the scan token.
// ----------------------------------------------------------------------------
module mhpq_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [mhpq_pkg::IDX_W-1:0]            i_index,
    input  logic [mhpq_pkg::SLOT_W-1:0]           i_slot,
    input  mhpq_pkg::t_ctl                        i_ctl,
    input  mhpq_pkg::t_cell_out                   i_parent,
    input  mhpq_pkg::t_cell_out                   i_prev,
    input  mhpq_pkg::t_cell_out [mhpq_pkg::ARITY-1:0] i_child,
    output mhpq_pkg::t_cell_out                   o_cell
);

    mhpq_pkg::t_entry r_entry, n_entry;
    logic             r_mark, n_mark;
    logic             r_tok, n_tok;

    logic                          live, is_cnt, is_root;
    logic                          swap_up, go_down, hit, sel, up_in;
    mhpq_pkg::t_entry              best, up_entry;
    logic [mhpq_pkg::SLOT_W-1:0]   best_j;

    assign live    = mhpq_pkg::CNT_W'(i_index) < i_ctl.count;
    assign is_cnt  = mhpq_pkg::CNT_W'(i_index) == i_ctl.count;
    assign is_root = i_index == '0;

    always_comb begin
        best     = r_entry;
        best_j   = '0;
        up_in    = 1'b0;
        up_entry = i_child[0].entry;
        for (int j = 0; j < mhpq_pkg::ARITY; j++) begin
            if (i_child[j].live && mhpq_pkg::entry_less(i_child[j].entry, best)) begin
                best   = i_child[j].entry;
                best_j = mhpq_pkg::SLOT_W'(j + 1);
            end
            if (i_child[j].swap_up) begin
                up_in    = 1'b1;
                up_entry = i_child[j].entry;
            end
        end
    end

    assign swap_up = (i_ctl.op == mhpq_pkg::OP_UP) && r_mark && !is_root
                     && mhpq_pkg::entry_less(r_entry, i_parent.entry);
    assign go_down = (i_ctl.op == mhpq_pkg::OP_DOWN) && r_mark && (best_j != '0);
    assign hit     = (i_ctl.op == mhpq_pkg::OP_SCAN) && r_tok && live
                     && (r_entry.vertex == i_ctl.entry.vertex);
    assign sel     = ((i_ctl.op == mhpq_pkg::OP_SEL_COUNT) && is_cnt)
                     || ((i_ctl.op == mhpq_pkg::OP_SEL_TOK) && r_tok);

    always_comb begin
        n_entry = r_entry;
        n_mark  = r_mark;
        n_tok   = r_tok;
        case (i_ctl.op)
            mhpq_pkg::OP_WRITE: begin
                if (is_cnt) begin
                    n_entry = i_ctl.entry;
                    n_mark  = 1'b1;
                end
            end
            mhpq_pkg::OP_LOAD_ROOT: begin
                if (is_root) begin
                    n_entry = i_ctl.entry;
                    n_mark  = 1'b1;
                end
            end
            mhpq_pkg::OP_UP: begin
                n_mark = 1'b0;
                if (swap_up) begin
                    n_entry = i_parent.entry;
                end else if (up_in) begin
                    n_entry = up_entry;
                    n_mark  = 1'b1;
                end
            end
            mhpq_pkg::OP_DOWN: begin
                n_mark = 1'b0;
                if (go_down) begin
                    n_entry = best;
                end else if (i_parent.go_down && (i_parent.down_j == i_slot)) begin
                    n_entry = i_parent.entry;
                    n_mark  = 1'b1;
                end
            end
            mhpq_pkg::OP_SCAN_START: begin
                n_tok = is_root;
            end
            mhpq_pkg::OP_SCAN: begin
                n_tok = hit || (i_prev.tok && !i_prev.hit);
            end
            mhpq_pkg::OP_SET: begin
                if (r_tok) begin
                    n_entry.cost = i_ctl.entry.cost;
                    n_mark       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_mark <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_mark <= n_mark;
            r_tok  <= n_tok;
        end
    end

    assign o_cell.entry   = r_entry;
    assign o_cell.live    = live;
    assign o_cell.mark    = r_mark;
    assign o_cell.tok     = r_tok;
    assign o_cell.hit     = hit;
    assign o_cell.sel     = sel;
    assign o_cell.swap_up = swap_up;
    assign o_cell.go_down = go_down;
    assign o_cell.down_j  = best_j;

endmodule
